// File: rtl/core/vdn_pkg.sv
// Shared types and constants for the vector difference norm block.
package vdn_pkg;

    localparam int OUT_W  = 32;
    localparam int SQ_W   = 64;
    localparam int REM_W  = OUT_W + 2;
    localparam int STEPS  = 32;
    localparam int CNT_W  = 5;

    typedef struct packed {
        logic load;
        logic step;
    } vdn_ctl_t;

endpackage

// File: rtl/core/vector_difference_norms.sv
// Vector difference norms: L2, max absolute and max relative difference of two vectors.
// Each request carries one element pair in signed fixed point; s_ready is high only
// while the block is idle. An accepted element is loaded into the bit-serial squarer
// and the restoring divider, which run 32 steps side by side, and is then summed in
// the accumulate state. The element marked last adds 32 steps of the digit-by-digit
// square root and a move of the norms into the output register; a finished result
// waits there while the next vector streams in, and a second result is held back
// until it is taken.
module vector_difference_norms #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [VALUE_WIDTH-1:0] s_current_value,
    input  logic signed [VALUE_WIDTH-1:0] s_compare_value,
    input  logic                          s_last_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [vdn_pkg::OUT_W-1:0]     m_l2_norm,
    output logic [vdn_pkg::OUT_W-1:0]     m_linf_norm,
    output logic [vdn_pkg::OUT_W-1:0]     m_rinf_norm
);
    import vdn_pkg::*;

    localparam int AW = VALUE_WIDTH + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ELEM  = 3'd1;
    localparam logic [2:0] ST_ACCUM = 3'd2;
    localparam logic [2:0] ST_ROOT  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last_reg;
    logic             cur_pos_reg;
    logic [OUT_W-1:0] abs_reg;
    logic [SQ_W-1:0]  sum_reg, sum_next;
    logic [OUT_W-1:0] max_abs_reg, max_abs_next;
    logic [OUT_W-1:0] max_rel_reg, max_rel_next;
    logic             m_valid_reg, m_valid_next;
    logic [OUT_W-1:0] l2_reg, linf_reg, rinf_reg;

    logic             accept;
    logic             cnt_done;
    logic             out_load;
    logic [AW-1:0]    diff;
    logic [AW-1:0]    abs_diff;
    logic [SQ_W-1:0]  abs_wide;
    logic             abs_over;
    logic [OUT_W-1:0] abs_sat;
    logic             cur_pos;
    logic [SQ_W:0]    sum_add;
    logic [SQ_W-1:0]  square;
    logic [OUT_W-1:0] quotient;
    logic [OUT_W-1:0] root;
    vdn_ctl_t         elem_ctl;
    vdn_ctl_t         root_ctl;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign cnt_done = (cnt_reg == CNT_W'(STEPS - 1));
    assign out_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    assign diff     = {s_current_value[VALUE_WIDTH-1], s_current_value}
                    - {s_compare_value[VALUE_WIDTH-1], s_compare_value};
    assign abs_diff = diff[AW-1] ? (~diff + AW'(1)) : diff;
    assign abs_wide = SQ_W'(abs_diff);
    assign abs_over = |abs_wide[SQ_W-1:OUT_W];
    assign abs_sat  = abs_over ? {OUT_W{1'b1}} : abs_wide[OUT_W-1:0];
    assign cur_pos  = !s_current_value[VALUE_WIDTH-1] && (|s_current_value);

    assign elem_ctl.load = accept;
    assign elem_ctl.step = (state_reg == ST_ELEM);
    assign root_ctl.load = (state_reg == ST_ACCUM) && last_reg;
    assign root_ctl.step = (state_reg == ST_ROOT);

    vdn_square u_square (
        .aclk     (aclk),
        .ctl      (elem_ctl),
        .abs_val  (abs_sat),
        .abs_over (abs_over),
        .square   (square)
    );

    vdn_divide #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_divide (
        .aclk     (aclk),
        .ctl      (elem_ctl),
        .abs_diff (abs_diff),
        .divisor  (s_current_value),
        .quotient (quotient)
    );

    vdn_sqrt u_sqrt (
        .aclk     (aclk),
        .ctl      (root_ctl),
        .radicand (sum_next),
        .root     (root)
    );

    assign sum_add = {1'b0, sum_reg} + {1'b0, square};

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        max_abs_next = max_abs_reg;
        max_rel_next = max_rel_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_ELEM;
                    cnt_next   = {CNT_W{1'b0}};
                end
            end
            ST_ELEM: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_done) begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                sum_next = sum_add[SQ_W] ? {SQ_W{1'b1}} : sum_add[SQ_W-1:0];
                if (abs_reg > max_abs_reg) begin
                    max_abs_next = abs_reg;
                end
                if (cur_pos_reg && (quotient > max_rel_reg)) begin
                    max_rel_next = quotient;
                end
                cnt_next   = {CNT_W{1'b0}};
                state_next = last_reg ? ST_ROOT : ST_IDLE;
            end
            ST_ROOT: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    sum_next     = {SQ_W{1'b0}};
                    max_abs_next = {OUT_W{1'b0}};
                    max_rel_next = {OUT_W{1'b0}};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= {CNT_W{1'b0}};
            sum_reg     <= {SQ_W{1'b0}};
            max_abs_reg <= {OUT_W{1'b0}};
            max_rel_reg <= {OUT_W{1'b0}};
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            max_abs_reg <= max_abs_next;
            max_rel_reg <= max_rel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            last_reg    <= s_last_item;
            cur_pos_reg <= cur_pos;
            abs_reg     <= abs_sat;
        end
        if (out_load) begin
            l2_reg   <= root;
            linf_reg <= max_abs_reg;
            rinf_reg <= max_rel_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_l2_norm   = l2_reg;
    assign m_linf_norm = linf_reg;
    assign m_rinf_norm = rinf_reg;

endmodule

// File: rtl/core/vdn_square.sv
// Bit-serial squarer for the saturated absolute difference.
module vdn_square (
    input  logic                          aclk,
    input  vdn_pkg::vdn_ctl_t             ctl,
    input  logic [vdn_pkg::OUT_W-1:0]     abs_val,
    input  logic                          abs_over,
    output logic [vdn_pkg::SQ_W-1:0]      square
);
    import vdn_pkg::*;

    logic [SQ_W-1:0]  acc_reg;
    logic [OUT_W-1:0] mcand_reg;
    logic             over_reg;
    logic [OUT_W:0]   part_sum;

    assign part_sum = {1'b0, acc_reg[SQ_W-1:OUT_W]}
                    + {1'b0, (acc_reg[0] ? mcand_reg : {OUT_W{1'b0}})};

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            acc_reg   <= {{OUT_W{1'b0}}, abs_val};
            mcand_reg <= abs_val;
            over_reg  <= abs_over;
        end else if (ctl.step) begin
            acc_reg <= {part_sum, acc_reg[OUT_W-1:1]};
        end
    end

    assign square = over_reg ? {SQ_W{1'b1}} : acc_reg;

endmodule

// File: rtl/core/vdn_divide.sv
// Restoring bit-serial divider for the relative difference quotient.
module vdn_divide #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          aclk,
    input  vdn_pkg::vdn_ctl_t             ctl,
    input  logic [VALUE_WIDTH:0]          abs_diff,
    input  logic [VALUE_WIDTH-1:0]        divisor,
    output logic [vdn_pkg::OUT_W-1:0]     quotient
);
    import vdn_pkg::*;

    logic [SQ_W-1:0]        abs_wide;
    logic [SQ_W-1:0]        num_hi;
    logic [SQ_W-1:0]        num_lo;
    logic                   over_start;
    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [VALUE_WIDTH-1:0] den_reg;
    logic [OUT_W-1:0]       qn_reg;
    logic                   over_reg;
    logic [VALUE_WIDTH-1:0] shifted;
    logic                   fits;

    assign abs_wide   = SQ_W'(abs_diff);
    assign num_hi     = abs_wide >> (OUT_W - FRAC_BITS);
    assign num_lo     = abs_wide << FRAC_BITS;
    assign over_start = num_hi >= SQ_W'(divisor);

    assign shifted = {rem_reg[VALUE_WIDTH-2:0], qn_reg[OUT_W-1]};
    assign fits    = shifted >= den_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            rem_reg  <= num_hi[VALUE_WIDTH-1:0];
            den_reg  <= divisor;
            qn_reg   <= num_lo[OUT_W-1:0];
            over_reg <= over_start;
        end else if (ctl.step) begin
            rem_reg <= fits ? (shifted - den_reg) : shifted;
            qn_reg  <= {qn_reg[OUT_W-2:0], fits};
        end
    end

    assign quotient = over_reg ? {OUT_W{1'b1}} : qn_reg;

endmodule

// File: rtl/core/vdn_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per step.
module vdn_sqrt (
    input  logic                          aclk,
    input  vdn_pkg::vdn_ctl_t             ctl,
    input  logic [vdn_pkg::SQ_W-1:0]      radicand,
    output logic [vdn_pkg::OUT_W-1:0]     root
);
    import vdn_pkg::*;

    logic [SQ_W-1:0]  rad_reg;
    logic [REM_W-1:0] rem_reg;
    logic [OUT_W-1:0] root_reg;
    logic [REM_W+1:0] rem_shift;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] rem_diff;
    logic             take;

    assign rem_shift = {rem_reg, rad_reg[SQ_W-1:SQ_W-2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign take      = rem_shift >= trial;
    assign rem_diff  = rem_shift - trial;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            rad_reg  <= radicand;
            rem_reg  <= {REM_W{1'b0}};
            root_reg <= {OUT_W{1'b0}};
        end else if (ctl.step) begin
            rad_reg  <= {rad_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= take ? rem_diff[REM_W-1:0] : rem_shift[REM_W-1:0];
            root_reg <= {root_reg[OUT_W-2:0], take};
        end
    end

    assign root = root_reg;

endmodule

// File: rtl/core/vdn_check.sv
// Port-level assertions for the vector difference norm block, bound to the top level.
module vdn_check (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [vdn_pkg::OUT_W-1:0]     m_l2_norm,
    input logic [vdn_pkg::OUT_W-1:0]     m_linf_norm,
    input logic [vdn_pkg::OUT_W-1:0]     m_rinf_norm
);

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("block not idle after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while previous element in progress");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result appeared right after an accepted request");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_l2_norm)
            && $stable(m_linf_norm) && $stable(m_rinf_norm)))
        else $error("stalled result changed or dropped");

endmodule

bind vector_difference_norms vdn_check u_vdn_check (.*);

// File: tb/sv/vector_difference_norms_test.sv
// Self-checking testbench for the vector difference norm block: random stalls, predicted norms.
module vector_difference_norms_test;

    localparam int VW = 32;
    localparam int FB = 16;
    localparam int OW = vdn_pkg::OUT_W;
    localparam int TARGET_ITEMS = 1550;
    localparam int LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 80;
    localparam logic signed [VW-1:0] MAXV = 32'sh7FFF_FFFF;
    localparam logic signed [VW-1:0] MINV = 32'sh8000_0000;

    typedef struct {
        logic signed [VW-1:0] cur;
        logic signed [VW-1:0] cmp;
        logic                 last;
    } elem_pair_t;

    typedef struct {
        logic [OW-1:0] l2;
        logic [OW-1:0] linf;
        logic [OW-1:0] rinf;
    } norm_set_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic signed [VW-1:0] s_current_value = '0;
    logic signed [VW-1:0] s_compare_value = '0;
    logic                 s_last_item = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [OW-1:0]        m_l2_norm;
    logic [OW-1:0]        m_linf_norm;
    logic [OW-1:0]        m_rinf_norm;

    elem_pair_t pair_queue[$];
    norm_set_t  norms_due[$];
    norm_set_t  want;
    elem_pair_t next_pair;

    logic [63:0] acc_sq = '0;
    logic [31:0] peak_abs = '0;
    logic [31:0] peak_rel = '0;

    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    logic m_valid_q = 1'b0;
    logic send_calm = 1'b0;
    logic recv_calm = 1'b0;
    int   send_wait = 0;
    int   recv_wait = 0;
    int   total_items = 0;
    int   accepted_count = 0;
    int   bad_count = 0;
    int   cycle_count = 0;

    vector_difference_norms #(
        .VALUE_WIDTH(VW),
        .FRAC_BITS  (FB)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_current_value(s_current_value),
        .s_compare_value(s_compare_value),
        .s_last_item    (s_last_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_l2_norm      (m_l2_norm),
        .m_linf_norm    (m_linf_norm),
        .m_rinf_norm    (m_rinf_norm)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic logic [31:0] root_floor(input logic [63:0] x);
        logic [31:0] r;
        logic [31:0] t;
        logic [63:0] sq;
        int          i;
        r = '0;
        for (i = 31; i >= 0; i--) begin
            t = r | (32'd1 << i);
            sq = {32'd0, t} * {32'd0, t};
            if (sq <= x) r = t;
        end
        return r;
    endfunction

    function automatic logic [31:0] rel_ratio(input logic [63:0] mag, input logic [63:0] den);
        logic [63:0] q;
        if (mag / den >= (64'd1 << (32 - FB))) return '1;
        q = (mag << FB) / den;
        return q[31:0];
    endfunction

    task automatic absorb_pair(input logic signed [VW-1:0] cur,
                               input logic signed [VW-1:0] cmp,
                               input logic last);
        logic signed [63:0] c64;
        logic signed [63:0] d64;
        logic [63:0]        mag;
        logic [63:0]        sq;
        logic [31:0]        clip;
        logic [31:0]        rr;
        logic [63:0]        l2;
        norm_set_t          n;
        c64 = cur;
        d64 = c64 - cmp;
        mag = d64[63] ? 64'(-d64) : 64'(d64);
        sq = (mag >= (64'd1 << 32)) ? '1 : mag * mag;
        acc_sq = (acc_sq > ~sq) ? '1 : acc_sq + sq;
        clip = (mag > 64'hFFFF_FFFF) ? '1 : mag[31:0];
        if (clip > peak_abs) peak_abs = clip;
        if (!c64[63] && c64 != 0) begin
            rr = rel_ratio(mag, c64);
            if (rr > peak_rel) peak_rel = rr;
        end
        if (last) begin
            l2 = {32'd0, root_floor(acc_sq)};
            n.l2 = (l2 > 64'hFFFF_FFFF) ? '1 : l2[31:0];
            n.linf = peak_abs;
            n.rinf = peak_rel;
            norms_due.push_back(n);
            acc_sq = '0;
            peak_abs = '0;
            peak_rel = '0;
        end
    endtask

    task automatic add_pair(input logic signed [VW-1:0] cur,
                            input logic signed [VW-1:0] cmp,
                            input logic last);
        elem_pair_t p;
        p.cur = cur;
        p.cmp = cmp;
        p.last = last;
        pair_queue.push_back(p);
        total_items++;
    endtask

    function automatic logic signed [VW-1:0] pick_value();
        int k;
        k = $urandom_range(0, 9);
        if (k <= 4) return $urandom;
        if (k <= 7) return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        case ($urandom_range(0, 4))
            0: return MAXV;
            1: return MINV;
            2: return 32'sd0;
            3: return 32'sd1;
            default: return -32'sd1;
        endcase
    endfunction

    task automatic add_random_vector();
        int                   len;
        int                   i;
        int                   mode;
        logic signed [VW-1:0] cur;
        logic signed [VW-1:0] cmp;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        for (i = 0; i < len; i++) begin
            mode = $urandom_range(0, 9);
            cur = pick_value();
            cmp = pick_value();
            if (mode >= 4 && mode <= 6) begin
                cur = $urandom_range(1, 32'h00FF_FFFF);
                cmp = cur + ($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
            end else if (mode == 7) begin
                cur = $urandom_range(1, 255);
            end else if (mode == 8) begin
                cmp = cur;
            end else if (mode == 9) begin
                cmp = cur + ($signed($urandom_range(0, 512)) - 32'sd256);
            end
            add_pair(cur, cmp, i == len - 1);
        end
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (in_fire) begin
                if ($urandom_range(0, 39) == 0) send_calm = ~send_calm;
                send_wait = send_calm ? 0 : $urandom_range(0, 15);
            end
            if (!s_valid || in_fire) begin
                if (send_wait > 0) begin
                    s_valid <= 1'b0;
                    send_wait--;
                end else if (pair_queue.size() != 0) begin
                    next_pair = pair_queue.pop_front();
                    s_valid <= 1'b1;
                    s_current_value <= next_pair.cur;
                    s_compare_value <= next_pair.cmp;
                    s_last_item <= next_pair.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            if (out_fire) begin
                if ($urandom_range(0, 19) == 0) recv_calm = ~recv_calm;
                recv_wait = recv_calm ? 0 : $urandom_range(0, 15);
            end
            if (recv_wait > 0) begin
                m_ready <= 1'b0;
                if (m_valid_q) recv_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        in_fire <= aresetn && s_valid && s_ready;
        out_fire <= aresetn && m_valid && m_ready;
        m_valid_q <= aresetn && m_valid;
        if (aresetn && m_valid && m_ready) begin
            if (norms_due.size() == 0) begin
                bad_count++;
                if (bad_count <= 10)
                    $display("unexpected result: l2 %h linf %h rinf %h",
                             m_l2_norm, m_linf_norm, m_rinf_norm);
            end else begin
                want = norms_due.pop_front();
                if (m_l2_norm !== want.l2 || m_linf_norm !== want.linf
                        || m_rinf_norm !== want.rinf) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("mismatch: l2 exp %h got %h, linf exp %h got %h, rinf exp %h got %h",
                                 want.l2, m_l2_norm, want.linf, m_linf_norm,
                                 want.rinf, m_rinf_norm);
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            absorb_pair(s_current_value, s_compare_value, s_last_item);
            accepted_count <= accepted_count + 1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        add_pair(32'sd0, 32'sd0, 1'b1);
        add_pair(MAXV, MINV, 1'b1);
        add_pair(MINV, MAXV, 1'b1);
        add_pair(MAXV, MINV, 1'b0);
        add_pair(MINV, MAXV, 1'b0);
        add_pair(MAXV, MINV, 1'b1);
        add_pair(32'sd1, 32'sh0001_0001, 1'b1);
        add_pair(32'sd1, -32'sd65534, 1'b1);
        add_pair(32'sd0, 32'sd12345, 1'b0);
        add_pair(-32'sd1, 32'sd70000, 1'b0);
        add_pair(MINV, 32'sd0, 1'b1);
        add_pair(32'sh0001_0000, 32'sh0000_8000, 1'b0);
        add_pair(32'sh0001_0000, 32'sh0001_0000, 1'b1);
        add_pair(MAXV, MAXV, 1'b1);
        add_pair(32'sd1, 32'sd0, 1'b0);
        add_pair(-32'sd1, 32'sd0, 1'b1);
        add_pair(32'sd1, MINV, 1'b0);
        add_pair(MAXV, 32'sd0, 1'b1);
        while (total_items < TARGET_ITEMS) add_random_vector();

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (accepted_count != total_items) @(posedge aclk);
        while (norms_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (bad_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
